[rtl/point_in_polygon_ray_cast_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ray-cast point-in-polygon block
// Shared forms for clocked assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_RAY_CAST_MACROS_SVH
`define POINT_IN_POLYGON_RAY_CAST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIPRAY_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pipray assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PIPRAY_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pipray assertion failed");

`endif

[rtl/pipray_pkg.sv]
// ----------------------------------------------------------------------------
// pipray_pkg
// Request codes, sequencer states and result layout of the ray-cast
// point-in-polygon block.
// ----------------------------------------------------------------------------
package pipray_pkg;

	// Request kinds carried on the slave tuser.
	typedef logic [1:0] req_t;
	localparam req_t REQ_CLEAR  = 2'd0;
	localparam req_t REQ_APPEND = 2'd1;
	localparam req_t REQ_QUERY  = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Result beat layout.
	localparam int M_TDATA_W   = 8;
	localparam int BIT_INSIDE  = 0;
	localparam int BIT_HIT     = 1;
	localparam int BIT_OVERFLOW = 2;

endpackage

[rtl/point_in_polygon_ray_cast.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast
// Keeps a list of polygon vertices and answers inside tests by counting
// crossings of a segment from the query point to a point below and left of
// every vertex. One pipelined edge-test unit is reused for every edge.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: point_x, point_y
//  m_*       out  m_tvalid/m_tready  tdata: inside_res, vertex_hit, overflowed
//
//  Clear and append finish in the cycle they are taken; an unused request code is dropped.
//  A query over N vertices makes N + 1 vertex reads (the last one wraps to
//  vertex 0), sends each edge through the edge-test pipeline, waits in drain
//  until it is empty, and loads the result. An empty polygon skips the walk.
//  Reset needs no clearing pass; a walk uses only vertices below the count.
//  A result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_cast
	import pipray_pkg::*;
#(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// tdata fields, low bit first: point_x, point_y
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]        s_tdata,
	// tuser fields, low bit first: req_type
	input  logic [1:0]                               s_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// tdata fields, low bit first: inside_res, vertex_hit, overflowed
	output logic [M_TDATA_W-1:0]                     m_tdata
);

	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int OW = COORD_BITS + 1;
	localparam int DW = COORD_BITS + 2;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [OW-1:0]         ocoord_t;
	typedef logic signed [DW-1:0]         diff_t;
	typedef logic signed [PW-1:0]         prod_t;
	typedef logic signed [XW-1:0]         cross_t;

	// Input unpacking.
	coord_t px;
	coord_t py;
	req_t   req;
	logic   accept;
	assign px     = coord_t'(s_tdata[COORD_BITS-1:0]);
	assign py     = coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
	assign req    = s_tuser;
	assign accept = s_tvalid && s_tready;

	// Sequencer and control state.
	state_t         state_q, state_d;
	logic [CW-1:0]  count_q;
	coord_t         lowest_x_q, lowest_y_q;
	logic           ovf_q;
	logic [CW-1:0]  rd_idx_q;
	logic           have_prev_q;
	logic           parity_q, hit_q;
	logic           m_tvalid_q;
	logic           rd_en, last_rd, pipe_empty, out_load, query_go;

	// Vertex memory and read data.
	coord_t         mem_x [MAX_VERTICES];
	coord_t         mem_y [MAX_VERTICES];
	logic [AW-1:0]  rd_addr;
	coord_t         rd_x_s1, rd_y_s1;
	logic           rdv_s1;

	// Query operands and edge-test pipeline.
	coord_t         qx_q, qy_q;
	ocoord_t        ox_q, oy_q;
	coord_t         prev_x_q, prev_y_q;
	logic           ev_s2, ev_s3, ev_s4, ev_s5;
	diff_t          a_s2, b_s2, c_s2, e_s2, f_s2, g_s2, h_s2, k_s2;
	prod_t          pab_s3, pce_s3, pfb_s3, pge_s3, phg_s3, pkf_s3;
	cross_t         d_s4, tn_s4, un_s4;
	logic           cross_s5, endp_s5;
	logic           launch;
	logic [M_TDATA_W-1:0] res_word;
	logic [M_TDATA_W-1:0] m_tdata_q;

	assign rd_addr = (rd_idx_q == count_q) ? '0 : rd_idx_q[AW-1:0];
	assign last_rd = (rd_idx_q == count_q);
	assign pipe_empty = !(rdv_s1 || ev_s2 || ev_s3 || ev_s4 || ev_s5);
	assign launch = rdv_s1 && have_prev_q;

	// Sequencer next state and strobes.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		query_go = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && req == REQ_QUERY) begin
					query_go = 1'b1;
					state_d  = (count_q == '0) ? ST_DONE : ST_WALK;
				end
			end
			ST_WALK: begin
				rd_en = 1'b1;
				if (last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pipe_empty) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Polygon bookkeeping, walk control, crossing tally and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			lowest_x_q  <= '0;
			lowest_y_q  <= '0;
			ovf_q       <= 1'b0;
			rd_idx_q    <= '0;
			have_prev_q <= 1'b0;
			parity_q    <= 1'b0;
			hit_q       <= 1'b0;
			rdv_s1      <= 1'b0;
			ev_s2       <= 1'b0;
			ev_s3       <= 1'b0;
			ev_s4       <= 1'b0;
			ev_s5       <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (accept && req == REQ_CLEAR) begin
				count_q    <= '0;
				lowest_x_q <= '0;
				lowest_y_q <= '0;
				ovf_q      <= 1'b0;
			end
			if (accept && req == REQ_APPEND) begin
				if (count_q == CW'(MAX_VERTICES)) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
					if (count_q == '0 || px < lowest_x_q) lowest_x_q <= px;
					if (count_q == '0 || py < lowest_y_q) lowest_y_q <= py;
				end
			end
			if (query_go) begin
				rd_idx_q    <= '0;
				have_prev_q <= 1'b0;
				parity_q    <= 1'b0;
				hit_q       <= 1'b0;
			end else begin
				if (rd_en && !last_rd) rd_idx_q <= rd_idx_q + 1'b1;
				if (rdv_s1) have_prev_q <= 1'b1;
				if (ev_s5 && cross_s5) begin
					parity_q <= ~parity_q;
					if (endp_s5) hit_q <= 1'b1;
				end
			end
			rdv_s1 <= rd_en;
			ev_s2  <= launch;
			ev_s3  <= ev_s2;
			ev_s4  <= ev_s3;
			ev_s5  <= ev_s4;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Vertex memory: one write port for appends, one registered read port.
	always_ff @(posedge clk) begin
		if (accept && req == REQ_APPEND && count_q != CW'(MAX_VERTICES)) begin
			mem_x[count_q[AW-1:0]] <= px;
			mem_y[count_q[AW-1:0]] <= py;
		end
		rd_x_s1 <= mem_x[rd_addr];
		rd_y_s1 <= mem_y[rd_addr];
	end

	// Query operands and the previous vertex of the walk.
	always_ff @(posedge clk) begin
		if (query_go) begin
			qx_q <= px;
			qy_q <= py;
			ox_q <= OW'(lowest_x_q) - OW'(1);
			oy_q <= OW'(lowest_y_q) - OW'(1);
		end
		if (rdv_s1) begin
			prev_x_q <= rd_x_s1;
			prev_y_q <= rd_y_s1;
		end
	end

	// Edge test, stage 2: differences of the query segment and the edge.
	always_ff @(posedge clk) begin
		a_s2 <= DW'(qx_q) - DW'(ox_q);
		c_s2 <= DW'(qy_q) - DW'(oy_q);
		h_s2 <= DW'(ox_q) - DW'(qx_q);
		k_s2 <= DW'(oy_q) - DW'(qy_q);
		b_s2 <= DW'(prev_y_q) - DW'(rd_y_s1);
		e_s2 <= DW'(prev_x_q) - DW'(rd_x_s1);
		f_s2 <= DW'(qx_q) - DW'(prev_x_q);
		g_s2 <= DW'(qy_q) - DW'(prev_y_q);
	end

	// Edge test, stage 3: the six products.
	always_ff @(posedge clk) begin
		pab_s3 <= PW'(a_s2) * PW'(b_s2);
		pce_s3 <= PW'(c_s2) * PW'(e_s2);
		pfb_s3 <= PW'(f_s2) * PW'(b_s2);
		pge_s3 <= PW'(g_s2) * PW'(e_s2);
		phg_s3 <= PW'(h_s2) * PW'(g_s2);
		pkf_s3 <= PW'(k_s2) * PW'(f_s2);
	end

	// Edge test, stage 4: denominator and the two numerators.
	always_ff @(posedge clk) begin
		d_s4  <= XW'(pab_s3) - XW'(pce_s3);
		tn_s4 <= XW'(pfb_s3) - XW'(pge_s3);
		un_s4 <= XW'(phg_s3) - XW'(pkf_s3);
	end

	// Edge test, stage 5: both parameters within the closed unit interval.
	logic d_zero, d_pos, tn_zero, un_zero, t_ok, u_ok;
	always_comb begin
		d_zero  = (d_s4 == '0);
		d_pos   = !d_s4[XW-1] && !d_zero;
		tn_zero = (tn_s4 == '0);
		un_zero = (un_s4 == '0);
		if (d_pos) begin
			t_ok = !tn_s4[XW-1] && (tn_s4 <= d_s4);
			u_ok = !un_s4[XW-1] && (un_s4 <= d_s4);
		end else begin
			t_ok = (tn_s4[XW-1] || tn_zero) && (tn_s4 >= d_s4);
			u_ok = (un_s4[XW-1] || un_zero) && (un_s4 >= d_s4);
		end
	end

	always_ff @(posedge clk) begin
		cross_s5 <= !d_zero && t_ok && u_ok;
		endp_s5  <= un_zero || (un_s4 == d_s4);
	end

	// Result word assembled from the tally and the overflow flag.
	always_comb begin
		res_word               = '0;
		res_word[BIT_INSIDE]   = parity_q ^ hit_q;
		res_word[BIT_HIT]      = hit_q;
		res_word[BIT_OVERFLOW] = ovf_q;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= res_word;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/pipray_checker.sv]
// ----------------------------------------------------------------------------
// pipray_checker
// Port-level checks on the ray-cast point-in-polygon block.
// ----------------------------------------------------------------------------
`include "point_in_polygon_ray_cast_macros.svh"

module pipray_checker
	import pipray_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [1:0]           s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// A stalled result beat holds.
	`PIPRAY_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// An accepted query makes the block busy for at least the next cycle.
	`PIPRAY_ASSERT_NEXT(a_query_busy, clk, arst_n, s_tvalid && s_tready && s_tuser == REQ_QUERY, !s_tready)

	// Clear, append and unused codes finish in the cycle they are taken.
	`PIPRAY_ASSERT_NEXT(a_other_quick, clk, arst_n, s_tvalid && s_tready && s_tuser != REQ_QUERY, s_tready)

	// A new result appears only at the end of a busy query.
	`PIPRAY_ASSERT_NOW(a_result_after_busy, clk, arst_n, $rose(m_tvalid), !$past(s_tready))

endmodule

bind point_in_polygon_ray_cast pipray_checker u_pipray_checker (.*);
